@@ src/vss_pkg.sv @@
// Shared types and constants for the variation support scalar block.
// Used by vss_div and variation_support_scalar_top; depends on nothing else.
package vss_pkg;

    // Field widths fixed by the item format.
    localparam int COORD_W  = 16;
    localparam int SCALAR_W = 15;
    localparam int IN_DATA_W  = 4 * COORD_W;
    localparam int OUT_DATA_W = 16;

    // Sequencer states, one-hot.
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_OUT  = 4'b1000
    } vss_state_t;

    // Status of the shared divider as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

@@ src/vss_div.sv @@
// Iterative restoring divider producing QW fraction bits of num / den.
// Requires num < den; one quotient bit per cycle. Depends on vss_pkg.
module vss_div
    import vss_pkg::*;
#(
    parameter int QW = 14
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [COORD_W-1:0] num,
    input  logic [COORD_W-1:0] den,
    output div_status_t        status,
    output logic [QW-1:0]      quot
);

    localparam int CW = $clog2(QW + 1);

    logic [COORD_W-1:0] rem_reg, rem_next;
    logic [COORD_W-1:0] den_reg, den_next;
    logic [QW-1:0]      quot_reg, quot_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    logic [COORD_W:0] shifted;
    logic [COORD_W:0] diff;
    logic             fits;

    // One trial subtraction per step.
    always_comb begin
        shifted = {rem_reg, 1'b0};
        diff    = shifted - {1'b0, den_reg};
        fits    = (shifted >= {1'b0, den_reg});
    end

    // Step control.
    always_comb begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = num;
            den_next  = den;
            cnt_next  = CW'(QW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = fits ? diff[COORD_W-1:0] : rem_reg << 1;
            quot_next = {quot_reg[QW-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state is reset; datapath registers are not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quot        = quot_reg;

endmodule

@@ src/variation_support_scalar_top.sv @@
// A skipped or zeroing axis is settled in the idle state as it is accepted; an axis
// with a tent ratio passes the divider (one divider step per quotient bit), a hand-off
// and one multiply. A last axis then loads the result register once it is free; the
// result waits there. A new axis is taken only once the previous one is fully handled.
// Reset: synchronous, active-low aresetn; running product returns to 1.0.
// Depends on vss_pkg and vss_div.
module variation_support_scalar_top
    import vss_pkg::*;
#(
    parameter int FRAC_BITS = 14
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [15:0] lower_edge, [31:16] peak_point, [47:32] upper_edge, [63:48] coordinate
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // [0] has_support
    input  logic                  s_tuser,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [14:0] scalar, [15] zero
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int PW = FRAC_BITS + 1;
    localparam logic [PW-1:0] ONE_FIXED = PW'(1) << FRAC_BITS;

    vss_state_t state_reg, state_next;
    logic [PW-1:0]       product_reg, product_next;
    logic                last_reg, last_next;
    logic                m_valid_reg, m_valid_next;
    logic [SCALAR_W-1:0] scalar_reg, scalar_next;

    logic signed [COORD_W-1:0] lo, pk, hi, v;
    logic                      s_acc;
    logic                      skip, outside, rising;
    logic [COORD_W:0]          num_wide, den_wide;
    logic                      div_start;
    div_status_t               div_st;
    logic [FRAC_BITS-1:0]      ratio;
    logic [2*FRAC_BITS:0]      mul_full;
    logic [PW+SCALAR_W-1:0]    product_ext;

    // Unpack the axis item.
    always_comb begin
        lo = s_tdata[COORD_W-1:0];
        pk = s_tdata[2*COORD_W-1:COORD_W];
        hi = s_tdata[3*COORD_W-1:2*COORD_W];
        v  = s_tdata[4*COORD_W-1:3*COORD_W];
    end

    // Classify the axis and form the ratio operands.
    always_comb begin
        skip = !s_tuser || (pk == '0) || (lo > pk) || (pk > hi) ||
               ((lo < 0) && (hi > 0)) || (v == pk);
        outside = (v <= lo) || (hi <= v);
        rising  = (v < pk);
        if (rising) begin
            num_wide = {v[COORD_W-1], v} - {lo[COORD_W-1], lo};
            den_wide = {pk[COORD_W-1], pk} - {lo[COORD_W-1], lo};
        end else begin
            num_wide = {hi[COORD_W-1], hi} - {v[COORD_W-1], v};
            den_wide = {hi[COORD_W-1], hi} - {pk[COORD_W-1], pk};
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign div_start = s_acc && !skip && !outside;

    vss_div #(
        .QW (FRAC_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num_wide[COORD_W-1:0]),
        .den     (den_wide[COORD_W-1:0]),
        .status  (div_st),
        .quot    (ratio)
    );

    // Product update multiply and the masked result.
    assign mul_full    = product_reg * ratio;
    assign product_ext = {{SCALAR_W{1'b0}}, product_reg};

    // Sequencer.
    always_comb begin
        state_next   = state_reg;
        product_next = product_reg;
        last_next    = last_reg;
        m_valid_next = m_valid_reg && !m_tready;
        scalar_next  = scalar_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    last_next = s_tlast;
                    if (!skip && outside) begin
                        product_next = '0;
                    end
                    if (div_start) begin
                        state_next = ST_DIV;
                    end else if (s_tlast) begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_DIV: begin
                if (div_st.done) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                product_next = mul_full[2*FRAC_BITS:FRAC_BITS];
                state_next   = last_reg ? ST_OUT : ST_IDLE;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    scalar_next  = product_ext[SCALAR_W-1:0];
                    product_next = ONE_FIXED;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            product_reg <= ONE_FIXED;
            last_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            product_reg <= product_next;
            last_reg    <= last_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scalar_reg <= scalar_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - SCALAR_W){1'b0}}, scalar_reg};

`ifndef SYNTHESIS
    // The divider only runs while the sequencer waits on it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_st.busy |-> (state_reg == ST_DIV))
        else $error("divider busy outside the divide state");

    // The running product never exceeds 1.0.
    assert property (@(posedge aclk) disable iff (!aresetn)
        product_reg <= ONE_FIXED)
        else $error("running product above 1.0");

    // A skipped last axis goes straight to result loading.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_tlast && skip) |=> (state_reg == ST_OUT))
        else $error("skipped last axis did not reach result loading");

    // Loading a result leaves the product at 1.0.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_OUT) && (!m_valid_reg || m_tready)) |=>
            (m_valid_reg && (product_reg == ONE_FIXED)))
        else $error("result load did not restore the product");
`endif

endmodule

@@ dv/variation_support_scalar_top_tb.sv @@
// Self-checking testbench for variation_support_scalar_top: a directed table, then random
// locations, checked against typed weights or an in-bench model of the per-axis tent-factor product.
// Depends on vss_pkg and the RTL of the block; reads no files.
module variation_support_scalar_top_tb
    import vss_pkg::*;
();

    localparam int FRAC_BITS    = 14;
    localparam int UNITY        = 1 << FRAC_BITS;
    localparam int PREDICT      = -1;
    localparam int RANDOM_AXES  = 1630;
    localparam int HOLD_CYCLES  = 600;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = FRAC_BITS + 8;

    // One axis as the sender sees it; typed_weight is the hand-written result, if any.
    typedef struct {
        bit                          has_support;
        logic signed [COORD_W-1:0]   lower;
        logic signed [COORD_W-1:0]   peak;
        logic signed [COORD_W-1:0]   upper;
        logic signed [COORD_W-1:0]   coord;
        bit                          last;
        int                          typed_weight;
    } axis_item_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    longint                weight_product = longint'(UNITY);
    logic [SCALAR_W-1:0]   expected_weights[$];
    axis_item_t            directed_rows[$];
    int                    mismatches = 0;
    int                    burst_left = 0;
    int                    idle_cycles = 0;

    variation_support_scalar_top #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // Free-running clock.
    initial begin
        forever #5 aclk = ~aclk;
    end

    // Fold one accepted axis into the product; on the last axis queue the weight.
    function automatic void apply_axis(input axis_item_t a);
        longint lo, pk, hi, v, ratio;
        bit     skip;
        lo = longint'(a.lower);
        pk = longint'(a.peak);
        hi = longint'(a.upper);
        v  = longint'(a.coord);
        skip = !a.has_support || pk == 0 || lo > pk || pk > hi ||
               (lo < 0 && hi > 0) || v == pk;
        if (!skip) begin
            if (v <= lo || hi <= v) begin
                weight_product = 0;
            end else begin
                if (v < pk) begin
                    ratio = ((v - lo) << FRAC_BITS) / (pk - lo);
                end else begin
                    ratio = ((hi - v) << FRAC_BITS) / (hi - pk);
                end
                weight_product = (weight_product * ratio) >> FRAC_BITS;
            end
        end
        if (a.last) begin
            if (a.typed_weight != PREDICT) begin
                expected_weights = {expected_weights, a.typed_weight[SCALAR_W-1:0]};
            end else begin
                expected_weights = {expected_weights, weight_product[SCALAR_W-1:0]};
            end
            weight_product = longint'(UNITY);
        end
    endfunction

    function automatic void add_row(input bit sup, input int lo, input int pk, input int hi,
                                    input int v, input bit last, input int want);
        axis_item_t a;
        a.has_support  = sup;
        a.lower        = COORD_W'(lo);
        a.peak         = COORD_W'(pk);
        a.upper        = COORD_W'(hi);
        a.coord        = COORD_W'(v);
        a.last         = last;
        a.typed_weight = want;
        directed_rows = {directed_rows, a};
    endfunction

    // Mostly well-formed supports on one side of zero, with some broken and raw items.
    function automatic axis_item_t random_axis(input bit last);
        axis_item_t a;
        int kind, span, pk_mag, lo_mag, hi_mag, lo, pk, hi, v, pick, t;
        kind = $urandom_range(0, 99);
        a.last = last;
        a.typed_weight = PREDICT;
        if (kind < 8) begin
            a.has_support = 1'($urandom_range(0, 1));
            a.lower = COORD_W'($urandom);
            a.peak  = COORD_W'($urandom);
            a.upper = COORD_W'($urandom);
            a.coord = COORD_W'($urandom);
            return a;
        end
        span   = ($urandom_range(0, 9) == 0) ? 32767 : UNITY;
        pk_mag = $urandom_range(1, span);
        lo_mag = $urandom_range(0, pk_mag);
        hi_mag = $urandom_range(pk_mag, span);
        if ($urandom_range(0, 1)) begin
            lo = lo_mag;
            pk = pk_mag;
            hi = hi_mag;
        end else begin
            lo = -hi_mag;
            pk = -pk_mag;
            hi = -lo_mag;
        end
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            v = pk;
        end else if (pick == 1) begin
            v = lo - $urandom_range(0, 300);
        end else if (pick == 2) begin
            v = hi + $urandom_range(0, 300);
        end else begin
            v = lo + $urandom_range(0, hi - lo);
        end
        // A few supports are given out of order.
        if (kind < 14) begin
            t  = lo;
            lo = hi;
            hi = t;
        end
        a.has_support = ($urandom_range(0, 19) != 0);
        a.lower = COORD_W'(lo);
        a.peak  = COORD_W'(pk);
        a.upper = COORD_W'(hi);
        a.coord = COORD_W'(v);
        return a;
    endfunction

    // Offer one item in bursts with random gaps, and hold it until it is accepted.
    task automatic send_axis(input axis_item_t a);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {a.coord, a.upper, a.peak, a.lower};
        s_tuser  <= a.has_support;
        s_tlast  <= a.last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        apply_axis(a);
    endtask

    // Stimulus and end of run.
    initial begin
        int n;
        int sent;
        add_row(0, 0, 16384, 16384, 8192, 1, UNITY);        // axis without support
        add_row(1, 0, 0, 16384, 100, 1, UNITY);             // peak at zero
        add_row(1, 12000, 8192, 16384, 10000, 1, UNITY);    // lower above peak
        add_row(1, 0, 16384, 8192, 4000, 1, UNITY);         // peak above upper
        add_row(1, -8192, 4096, 8192, 2000, 1, UNITY);      // support spans zero
        add_row(1, 0, 16384, 16384, 16384, 1, UNITY);       // coordinate on the peak
        add_row(1, -1, -1, -1, -1, 1, UNITY);               // all-ones fields, on the peak
        add_row(1, 0, 8192, 16384, 0, 1, 0);                // at the lower edge
        add_row(1, 0, 8192, 16384, 16384, 1, 0);            // at the upper edge
        add_row(1, 0, 16384, 16384, 8192, 1, 8192);         // rising side, half way
        add_row(1, -16384, -16384, 0, -8192, 1, 8192);      // falling side, half way
        add_row(1, 0, 16384, 16384, 4096, 0, PREDICT);      // two-axis location
        add_row(1, -16384, -8192, 0, -2000, 1, PREDICT);
        add_row(1, 0, 8192, 16384, 20000, 0, PREDICT);      // a zero stays zero
        add_row(1, 0, 16384, 16384, 8192, 1, 0);
        add_row(1, 0, 16384, 16384, 12288, 0, PREDICT);     // skipped last axis
        add_row(0, -32768, 32767, -32768, 32767, 1, PREDICT);
        add_row(1, -32768, -1, -1, -32767, 1, PREDICT);     // widest negative support
        add_row(1, 1, 32767, 32767, 32766, 1, PREDICT);     // widest positive support
        add_row(1, 1, 1, 32767, 2, 1, PREDICT);
        add_row(1, -32768, -32768, -32768, 32767, 1, 0);
        add_row(1, -32768, 32767, -1, 0, 1, UNITY);
        add_row(1, 0, 16384, 16384, 15000, 0, PREDICT);     // three-axis location
        add_row(1, 1000, 9000, 16384, 3000, 0, PREDICT);
        add_row(1, -16384, -4000, -100, -2000, 1, PREDICT);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) send_axis(directed_rows[i]);

        // Random locations of one to four axes.
        sent = 0;
        while (sent < RANDOM_AXES) begin
            n = $urandom_range(1, 4);
            for (int k = 0; k < n; k++) begin
                send_axis(random_axis(k == n - 1));
                sent++;
            end
        end
        s_tvalid <= 1'b0;

        while (expected_weights.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && expected_weights.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Receiver: stretches of steady, random and sparse ready, with long hold-offs.
    initial begin
        int segment;
        int span;
        int mode;
        segment = 0;
        forever begin
            segment++;
            if (segment == 3 || segment % 50 == 0) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                span = $urandom_range(10, 200);
                mode = $urandom_range(0, 2);
                repeat (span) begin
                    if (mode == 0) begin
                        m_tready <= 1'b1;
                    end else if (mode == 1) begin
                        m_tready <= 1'($urandom_range(0, 1));
                    end else begin
                        m_tready <= ($urandom_range(0, 7) == 0);
                    end
                    @(posedge aclk);
                end
            end
        end
    end

    // Compare each accepted weight with the oldest expectation.
    always @(posedge aclk) begin : check_weight
        logic [SCALAR_W-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_weights.size() == 0) begin
                $display("%0t: weight %0d with none expected", $time,
                         m_tdata[SCALAR_W-1:0]);
                mismatches++;
            end else begin
                want = expected_weights.pop_front();
                if (m_tdata[SCALAR_W-1:0] !== want) begin
                    $display("%0t: weight mismatch, expected %0d, actual %0d", $time,
                             want, m_tdata[SCALAR_W-1:0]);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on cycles in which neither side moves an item.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

endmodule
